@@ src/rsort_pkg.sv @@
// Shared types and constants for the record sort with line totals block.
// Used by rsort_front, rsort_cmdq, rsort_back and the top level.
`default_nettype none

package rsort_pkg;

  localparam int KEY_W   = 32;
  localparam int QTY_W   = 32;
  localparam int PRICE_W = 32;
  localparam int TOTAL_W = 64;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;

  // One stored record
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [QTY_W-1:0]        qty;
    logic [PRICE_W-1:0]      price;
  } rsort_rec_t;

  // One classified word from the front to the back
  typedef struct packed {
    rsort_rec_t rec;
    logic       store;  // record goes into the store
    logic       last;   // closes the set
    logic       ovf;    // set saw a dropped record (meaningful with last)
  } rsort_cmd_t;

endpackage

`default_nettype wire

@@ src/record_sort_with_line_totals_core.sv @@
// Record sort with line totals: top level tying front, command queue and back.
// Depends on rsort_pkg, rsort_front, rsort_cmdq and rsort_back.
//
// Usage:
//   Input words (key, quantity, unit price, last flag) go in through push/full.
//   A word is taken when push is high and full is low. Up to MAX_RECORDS words
//   of a set are stored; later words are dropped and flag the whole set.
//   The word with last set closes the set: the stored records are sorted by
//   ascending signed key with an exchange sort and then handed out through
//   empty/pop, one result per record, each with its Q32.32 line total and a
//   saturating running sum; the final result of the set is flagged.
// Timing:
//   The front takes one word per cycle into a four-entry command queue while
//   the queue is not full; the back drains one command word per cycle while
//   idle. The sort passes through ST_RD_I and ST_LD_I to load each position,
//   ST_CMP for each later position and ST_WB_I to write the held record back,
//   as the record store has a single write port. Each result then passes
//   through store read, multiply and sum (ST_EM_RD, ST_EM_MUL, ST_EM_OUT).
// Reset clears the control state; the store needs no clearing pass. When the
// receiver holds pop low, the back stalls on the result register and the
// queue fills, after which full rises.
`default_nettype none

module record_sort_with_line_totals_core #(
  parameter int MAX_RECORDS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [31:0] in_record_key,
  input  wire logic [31:0]        in_quantity,
  input  wire logic [31:0]        in_unit_price,
  input  wire logic               in_last_record,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      out_key,
  output logic [31:0]             out_quantity,
  output logic [31:0]             out_price,
  output logic [63:0]             out_line_total,
  output logic [63:0]             out_running_total,
  output logic                    out_dropped_flag,
  output logic                    out_final_result
);
  import rsort_pkg::*;

  logic       q_push, q_full, q_pop, q_valid;
  rsort_cmd_t q_cmd, q_head;

  rsort_front #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_record_key  (in_record_key),
    .in_quantity    (in_quantity),
    .in_unit_price  (in_unit_price),
    .in_last_record (in_last_record),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  rsort_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .cmd_in (q_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .head   (q_head)
  );

  rsort_back #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_key           (out_key),
    .out_quantity      (out_quantity),
    .out_price         (out_price),
    .out_line_total    (out_line_total),
    .out_running_total (out_running_total),
    .out_dropped_flag  (out_dropped_flag),
    .out_final_result  (out_final_result)
  );

`ifndef NO_ASSERTIONS
  // Front never writes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command written into full queue");

  // Back only takes commands that are present
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command taken from empty queue");

  // Running sum never falls below the line total it includes
  a_sum_ge_line: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_running_total >= out_line_total))
    else $error("running total below line total");

  // A closing word with no queue space must not be lost: full blocks accept
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |-> !q_push)
    else $error("word classified while queue full");
`endif

endmodule

`default_nettype wire

@@ src/rsort_front.sv @@
// Front end: accepts input words, tracks set fill and classifies each word
// as stored or dropped. Depends on rsort_pkg; feeds rsort_cmdq.
`default_nettype none

module rsort_front #(
  parameter int MAX_RECORDS = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic signed [31:0]      in_record_key,
  input  wire logic [31:0]             in_quantity,
  input  wire logic [31:0]             in_unit_price,
  input  wire logic                    in_last_record,
  input  wire logic                    q_full,
  output logic                         q_push,
  output rsort_pkg::rsort_cmd_t        q_cmd
);
  import rsort_pkg::*;

  localparam int CW = $clog2(MAX_RECORDS + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          accept;
  logic          store;

  // Classify the incoming word
  assign full   = q_full;
  assign accept = push && !q_full;
  assign store  = (cnt_r != CW'(MAX_RECORDS));
  assign q_push = accept && (store || in_last_record);

  always_comb begin
    q_cmd.rec.key   = in_record_key;
    q_cmd.rec.qty   = in_quantity;
    q_cmd.rec.price = in_unit_price;
    q_cmd.store     = store;
    q_cmd.last      = in_last_record;
    q_cmd.ovf       = ovf_r || !store;
  end

  // Advance the fill count; clear it when a set closes
  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (accept) begin
      if (in_last_record) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (store) begin
        cnt_nxt = cnt_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/rsort_cmdq.sv @@
// Short command queue that decouples the front from the back.
// Depends on rsort_pkg for the command word and depth.
`default_nettype none

module rsort_cmdq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire rsort_pkg::rsort_cmd_t   cmd_in,
  output logic                         full,
  input  wire logic                    pop,
  output logic                         valid,
  output rsort_pkg::rsort_cmd_t        head
);
  import rsort_pkg::*;

  rsort_cmd_t               entry_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CMDQ_AW:0]         fill_r;
  logic                     do_push, do_pop;

  assign full    = (fill_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign valid   = (fill_r != '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CMDQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + (CMDQ_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - (CMDQ_AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/rsort_back.sv @@
// Back end: record store, exchange sort sequencer, line total multiplier,
// saturating running sum and result register. Depends on rsort_pkg.
`default_nettype none

module rsort_back #(
  parameter int MAX_RECORDS = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_valid,
  input  wire rsort_pkg::rsort_cmd_t   q_head,
  output logic                         q_pop,
  output logic                         empty,
  input  wire logic                    pop,
  output logic signed [31:0]           out_key,
  output logic [31:0]                  out_quantity,
  output logic [31:0]                  out_price,
  output logic [63:0]                  out_line_total,
  output logic [63:0]                  out_running_total,
  output logic                         out_dropped_flag,
  output logic                         out_final_result
);
  import rsort_pkg::*;

  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_CMP,
    ST_WB_I,
    ST_EM_RD,
    ST_EM_MUL,
    ST_EM_OUT
  } state_t;

  // Record store
  rsort_rec_t mem [MAX_RECORDS];
  rsort_rec_t rd_data_r;
  logic       mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  rsort_rec_t mem_wdata;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [TOTAL_W-1:0] sum_r, sum_nxt;
  logic          out_valid_r, out_valid_nxt;
  rsort_rec_t    cur_r, cur_nxt;
  rsort_rec_t    rec_r, rec_nxt;
  logic [TOTAL_W-1:0] prod_r, prod_nxt;
  rsort_rec_t    out_rec_r, out_rec_nxt;
  logic [TOTAL_W-1:0] out_line_r, out_line_nxt;
  logic [TOTAL_W-1:0] out_sum_r, out_sum_nxt;
  logic          out_drop_r, out_drop_nxt;
  logic          out_final_r, out_final_nxt;

  logic [CW-1:0]  cnt_after;
  logic [TOTAL_W:0] sum_wide;
  logic [TOTAL_W-1:0] sum_sat;
  logic          out_pop;
  logic          out_free;
  logic          is_final;

  assign out_pop  = pop && out_valid_r;
  assign out_free = !out_valid_r || out_pop;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  // Saturating add of the line total to the running sum
  assign sum_wide = {1'b0, sum_r} + {1'b0, prod_r};
  assign sum_sat  = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];
  assign is_final = ((CW'(k_r) + CW'(1)) == cnt_r);
  assign cnt_after = q_head.store ? (cnt_r + CW'(1)) : cnt_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    cur_nxt       = cur_r;
    rec_nxt       = rec_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_rec_nxt   = out_rec_r;
    out_line_nxt  = out_line_r;
    out_sum_nxt   = out_sum_r;
    out_drop_nxt  = out_drop_r;
    out_final_nxt = out_final_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = cur_r;
    mem_raddr     = '0;

    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Take commands: store records, start the sort (or, for a single record, the output) on the closing word
      ST_IDLE: begin
        if (q_valid) begin
          if (q_head.store) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[AW-1:0];
            mem_wdata = q_head.rec;
          end
          cnt_nxt = cnt_after;
          if (q_head.last) begin
            ovf_nxt = q_head.ovf;
            i_nxt   = '0;
            k_nxt   = '0;
            if (cnt_after >= CW'(2)) begin
              state_nxt = ST_RD_I;
            end else begin
              state_nxt = ST_EM_RD;
            end
          end
        end
      end
      // Fetch the record at position i
      ST_RD_I: begin
        mem_raddr = i_r;
        j_nxt     = i_r + AW'(1);
        state_nxt = ST_LD_I;
      end
      // Hold record i, fetch the first j
      ST_LD_I: begin
        cur_nxt   = rd_data_r;
        mem_raddr = j_r;
        state_nxt = ST_CMP;
      end
      // Compare j against the held record, swap on a smaller key
      ST_CMP: begin
        if ($signed(rd_data_r.key) < $signed(cur_r.key)) begin
          mem_we    = 1'b1;
          mem_waddr = j_r;
          mem_wdata = cur_r;
          cur_nxt   = rd_data_r;
        end
        if ((CW'(j_r) + CW'(1)) == cnt_r) begin
          state_nxt = ST_WB_I;
        end else begin
          j_nxt     = j_r + AW'(1);
          mem_raddr = j_r + AW'(1);
        end
      end
      // Write back position i and move on
      ST_WB_I: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = cur_r;
        i_nxt     = i_r + AW'(1);
        if ((CW'(i_r) + CW'(2)) == cnt_r) begin
          state_nxt = ST_EM_RD;
        end else begin
          state_nxt = ST_RD_I;
        end
      end
      // Fetch the next sorted record
      ST_EM_RD: begin
        mem_raddr = k_r;
        state_nxt = ST_EM_MUL;
      end
      // Form the line total
      ST_EM_MUL: begin
        rec_nxt   = rd_data_r;
        prod_nxt  = TOTAL_W'(rd_data_r.qty) * TOTAL_W'(rd_data_r.price);
        state_nxt = ST_EM_OUT;
      end
      // Load the result register once it is free
      ST_EM_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rec_nxt   = rec_r;
          out_line_nxt  = prod_r;
          out_sum_nxt   = sum_sat;
          out_drop_nxt  = ovf_r;
          out_final_nxt = is_final;
          if (is_final) begin
            sum_nxt   = '0;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            sum_nxt   = sum_sat;
            k_nxt     = k_r + AW'(1);
            state_nxt = ST_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
    end
    cur_r       <= cur_nxt;
    rec_r       <= rec_nxt;
    prod_r      <= prod_nxt;
    out_rec_r   <= out_rec_nxt;
    out_line_r  <= out_line_nxt;
    out_sum_r   <= out_sum_nxt;
    out_drop_r  <= out_drop_nxt;
    out_final_r <= out_final_nxt;
  end

  // Store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Store read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[mem_raddr];
  end

  assign empty             = !out_valid_r;
  assign out_key           = out_rec_r.key;
  assign out_quantity      = out_rec_r.qty;
  assign out_price         = out_rec_r.price;
  assign out_line_total    = out_line_r;
  assign out_running_total = out_sum_r;
  assign out_dropped_flag  = out_drop_r;
  assign out_final_result  = out_final_r;

endmodule

`default_nettype wire

@@ verif/tb_record_sort_with_line_totals_core.sv @@
// Self-checking testbench for record_sort_with_line_totals_core.
// Uses rsort_pkg for field widths and the stored record type; needs only the RTL.
`timescale 1ns / 1ps

module tb_record_sort_with_line_totals_core;
  import rsort_pkg::*;

  localparam int MAX_RECORDS  = 64;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 100;
  // Slowest run: words with random gaps, a handful of full sets and every result
  // held back by the receiver's random gaps; well under this bound.
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [QTY_W-1:0] Q_MAX = '1;
  localparam logic [QTY_W-1:0] Q_ONE = 32'h0001_0000;

  // One expected or observed result word
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [QTY_W-1:0]        qty;
    logic [PRICE_W-1:0]      price;
    logic [TOTAL_W-1:0]      line;
    logic [TOTAL_W-1:0]      running;
    logic                    dropped;
    logic                    is_last;
  } line_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     push;
  logic                     full;
  logic signed [KEY_W-1:0]  in_record_key;
  logic [QTY_W-1:0]         in_quantity;
  logic [PRICE_W-1:0]       in_unit_price;
  logic                     in_last_record;
  logic                     empty;
  logic                     pop;
  logic signed [KEY_W-1:0]  out_key;
  logic [QTY_W-1:0]         out_quantity;
  logic [PRICE_W-1:0]       out_price;
  logic [TOTAL_W-1:0]       out_line_total;
  logic [TOTAL_W-1:0]       out_running_total;
  logic                     out_dropped_flag;
  logic                     out_final_result;

  // Predictor state: records of the set being loaded
  rsort_rec_t   set_recs [MAX_RECORDS];
  int           set_count;
  bit           set_dropped;
  line_result_t expected_lines [$];

  bit no_idle;
  int cycle_count;
  int mismatch_count;
  int results_checked;
  int records_sent;
  int sets_sent;
  int dropped_sets;

  record_sort_with_line_totals_core #(
    .MAX_RECORDS(MAX_RECORDS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_record_key     (in_record_key),
    .in_quantity       (in_quantity),
    .in_unit_price     (in_unit_price),
    .in_last_record    (in_last_record),
    .empty             (empty),
    .pop               (pop),
    .out_key           (out_key),
    .out_quantity      (out_quantity),
    .out_price         (out_price),
    .out_line_total    (out_line_total),
    .out_running_total (out_running_total),
    .out_dropped_flag  (out_dropped_flag),
    .out_final_result  (out_final_result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_lines.size());
      $display("record_sort_with_line_totals_core regression: fail");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Mix of extremes, small values and full-range Q16.16 values
  function automatic logic [QTY_W-1:0] draw_q16();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return Q_MAX;
      2:       return $urandom_range(0, 8) << 16;
      3:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [KEY_W-1:0] draw_key(input bit narrow);
    if (narrow) return $urandom_range(0, 7) - 4;
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Store one accepted word; on the last word sort the set and predict its results
  task automatic predict_record(input rsort_rec_t rec, input bit last);
    rsort_rec_t         tmp;
    logic [TOTAL_W:0]   acc;
    logic [TOTAL_W-1:0] sum;
    line_result_t       res;
    if (set_count < MAX_RECORDS) begin
      set_recs[set_count] = rec;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      // exchange sort: swap whenever a later key is smaller
      for (int i = 0; i + 1 < set_count; i++) begin
        for (int j = i + 1; j < set_count; j++) begin
          if ($signed(set_recs[j].key) < $signed(set_recs[i].key)) begin
            tmp = set_recs[i];
            set_recs[i] = set_recs[j];
            set_recs[j] = tmp;
          end
        end
      end
      sum = '0;
      for (int i = 0; i < set_count; i++) begin
        res.key     = set_recs[i].key;
        res.qty     = set_recs[i].qty;
        res.price   = set_recs[i].price;
        res.line    = TOTAL_W'(set_recs[i].qty) * TOTAL_W'(set_recs[i].price);
        acc         = {1'b0, sum} + {1'b0, res.line};
        sum         = acc[TOTAL_W] ? '1 : acc[TOTAL_W-1:0];
        res.running = sum;
        res.dropped = set_dropped;
        res.is_last = (i + 1 == set_count);
        expected_lines.push_back(res);
      end
      sets_sent++;
      if (set_dropped) dropped_sets++;
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  // Send one word after a random gap; push stays high for a following word
  task automatic send_record(input logic signed [KEY_W-1:0] key,
                             input logic [QTY_W-1:0] qty,
                             input logic [PRICE_W-1:0] price,
                             input bit last);
    int         gap;
    rsort_rec_t rec;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    in_record_key  <= key;
    in_quantity    <= qty;
    in_unit_price  <= price;
    in_last_record <= last;
    do @(posedge clk); while (full);
    rec.key   = key;
    rec.qty   = qty;
    rec.price = price;
    records_sent++;
    predict_record(rec, last);
  endtask

  // Hold the input idle until every predicted result has come back
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Single records, key and value extremes, and a saturating sum
  task automatic test_extremes();
    send_record(0, 0, 0, 1'b1);
    send_record(32'sh7FFF_FFFF, Q_MAX, Q_MAX, 1'b0);
    send_record(32'sh8000_0000, Q_MAX, Q_MAX, 1'b0);
    send_record(0, Q_ONE, Q_ONE, 1'b1);
    send_record(-1, Q_MAX, 0, 1'b0);
    send_record(1, 0, Q_MAX, 1'b1);
    wait_drained();
  endtask

  // Equal keys, reversed order and already sorted sets
  task automatic test_key_order();
    send_record(5, Q_ONE * 1, 32'h0000_8000, 1'b0);
    send_record(5, Q_ONE * 2, 32'h0000_8000, 1'b0);
    send_record(-1, Q_ONE * 3, 32'h0002_0000, 1'b0);
    send_record(5, Q_ONE * 4, 32'h0000_0001, 1'b0);
    send_record(5, Q_ONE * 5, 32'h0001_8000, 1'b1);
    for (int k = 3; k >= 0; k--) send_record(k, k + 1, Q_ONE, k == 0);
    send_record(-7, 32'h0000_0003, 32'h0000_0005, 1'b0);
    send_record(9, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    wait_drained();
  endtask

  // Exactly full set, then a set whose extra words (the last one too) are dropped
  task automatic test_capacity();
    for (int k = 0; k < MAX_RECORDS; k++) begin
      send_record(draw_key(k % 3 == 0), draw_q16(), draw_q16(), k == MAX_RECORDS - 1);
    end
    wait_drained();
    for (int k = 0; k < MAX_RECORDS + 3; k++) begin
      send_record(draw_key(1'b0), Q_MAX - k, Q_MAX, k == MAX_RECORDS + 2);
    end
    wait_drained();
    // a short set after overflow must come back with the flag clear
    send_record(2, Q_ONE, Q_ONE, 1'b0);
    send_record(1, Q_ONE, Q_ONE, 1'b1);
    wait_drained();
  endtask

  // Random sets, mostly small, some large and a few past capacity
  task automatic test_random_sets(input int word_target);
    int  sent;
    int  size;
    bit  narrow;
    bit  keep_idle;
    keep_idle = no_idle;
    sent = 0;
    while (sent < word_target) begin
      case ($urandom_range(0, 29))
        0:       size = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 6);
        1, 2:    size = $urandom_range(9, MAX_RECORDS);
        default: size = $urandom_range(1, 8);
      endcase
      narrow = ($urandom_range(0, 2) == 0);
      // occasional burst with neither side idling
      no_idle = keep_idle || ($urandom_range(0, 5) == 0);
      for (int k = 0; k < size; k++) begin
        send_record(draw_key(narrow), draw_q16(), draw_q16(), k == size - 1);
      end
      sent += size;
      // let results drain now and then so sets also start on an idle block
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    no_idle = keep_idle;
    wait_drained();
  endtask

  // Receiver: wait a random number of cycles, then pop until a word is taken
  initial begin : result_sink
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Compare each popped word with the oldest prediction
  always @(posedge clk) begin : check_results
    line_result_t got;
    line_result_t want;
    if (rst_n && pop && !empty) begin
      got.key     = out_key;
      got.qty     = out_quantity;
      got.price   = out_price;
      got.line    = out_line_total;
      got.running = out_running_total;
      got.dropped = out_dropped_flag;
      got.is_last = out_final_result;
      if (expected_lines.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: key %0d qty %h price %h line %h run %h",
                   got.key, got.qty, got.price, got.line, got.running);
        end
      end else begin
        want = expected_lines.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at result %0d:", results_checked);
            $display("  expected key %0d qty %h price %h line %h run %h drop %b last %b",
                     want.key, want.qty, want.price, want.line, want.running,
                     want.dropped, want.is_last);
            $display("  actual   key %0d qty %h price %h line %h run %h drop %b last %b",
                     got.key, got.qty, got.price, got.line, got.running,
                     got.dropped, got.is_last);
          end
        end
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    push           <= 1'b0;
    pop            <= 1'b0;
    in_record_key  <= '0;
    in_quantity    <= '0;
    in_unit_price  <= '0;
    in_last_record <= 1'b0;
    no_idle        = 1'b0;
    set_count      = 0;
    set_dropped    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_key_order();
    test_capacity();
    test_random_sets(200);
    no_idle = 1'b1;
    test_random_sets(55);
    no_idle = 1'b0;

    $display("sent %0d records in %0d sets (%0d with dropped records)",
             records_sent, sets_sent, dropped_sets);
    $display("checked %0d results, %0d mismatches, %0d cycles",
             results_checked, mismatch_count, cycle_count);
    if (mismatch_count == 0 && expected_lines.size() == 0) begin
      $display("record_sort_with_line_totals_core regression: pass");
    end else begin
      $display("record_sort_with_line_totals_core regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/rsort_pkg.sv
src/rsort_front.sv
src/rsort_cmdq.sv
src/rsort_back.sv
src/record_sort_with_line_totals_core.sv
verif/tb_record_sort_with_line_totals_core.sv
